// ===== hw/rtl/lfpf_pkg.sv =====
`timescale 1ns / 1ps

package lfpf_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 6;
    localparam int PREFIX_LEN    = 13;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    // "+MQTTSUBRECV:"
    localparam logic [BYTE_W-1:0] PREFIX_TEXT [PREFIX_LEN] = '{
        8'h2B, 8'h4D, 8'h51, 8'h54, 8'h54, 8'h53, 8'h55,
        8'h42, 8'h52, 8'h45, 8'h43, 8'h56, 8'h3A
    };

endpackage

// ===== hw/rtl/line_framer_prefix_filter_top.sv =====
`timescale 1ns / 1ps
// line framer with prefix filter
// timing: an ordinary byte is written to the ram as it is accepted, while there is room; a terminator
//   that ends a matching line starts a ram read (S_FETCH), then S_LOAD loads the first word when the slot is free
// throughput: 1 input byte per cycle while collecting; each word is emitted by a ram read (S_FETCH), then an
//   output register load (S_LOAD), and input is stalled until the last word is loaded
// reset: rst_n asynchronous, active low; clears count, state and output valid, and sets the match flag

module line_framer_prefix_filter_top #(
    parameter int LINE_CAPACITY = lfpf_pkg::LINE_CAPACITY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lfpf_pkg::BYTE_W-1:0] rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lfpf_pkg::BYTE_W-1:0] line_byte,
    output logic [lfpf_pkg::LEN_W-1:0]  line_length,
    output logic                       last_of_line
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] STORE_LIMIT = CNT_W'(LINE_CAPACITY - 1);
    localparam logic [CNT_W-1:0] PREFIX_CNT  = CNT_W'(lfpf_pkg::PREFIX_LEN);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_LOAD  = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        match_reg, match_next;
    logic [CNT_W-1:0]            len_reg, len_next;
    logic [CNT_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic                        valid_reg, valid_next;
    logic [lfpf_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                        last_reg, last_next;
    logic [CNT_W-1:0]            olen_reg, olen_next;

    logic                        accept;
    logic                        is_term;
    logic                        mem_we;
    logic                        mem_re;
    logic [lfpf_pkg::BYTE_W-1:0] mem_rdata;
    logic                        slot_free;
    logic                        at_last;

    lfpf_ram #(
        .WIDTH (lfpf_pkg::BYTE_W),
        .DEPTH (LINE_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg),
        .wdata (rx_byte),
        .re    (mem_re),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !valid_reg || !out_stall;
    assign at_last   = (rd_ptr_reg == CNT_W'(len_reg - 1'b1));

    always_comb
    begin
        is_term     = rx_byte inside {lfpf_pkg::CH_LF, lfpf_pkg::CH_CR};
        state_next  = state_reg;
        count_next  = count_reg;
        match_next  = match_reg;
        len_next    = len_reg;
        rd_ptr_next = rd_ptr_reg;
        valid_next  = valid_reg && out_stall;
        byte_next   = byte_reg;
        last_next   = last_reg;
        olen_next   = olen_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_term)
                    begin
                        if (count_reg != '0)
                        begin
                            if (match_reg && (count_reg >= PREFIX_CNT))
                            begin
                                len_next    = count_reg;
                                rd_ptr_next = '0;
                                state_next  = S_FETCH;
                            end
                            count_next = '0;
                            match_next = 1'b1;
                        end
                    end
                    else if (count_reg < STORE_LIMIT)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        // prefix is checked as the first characters arrive
                        if ((count_reg < PREFIX_CNT) &&
                            (rx_byte != lfpf_pkg::PREFIX_TEXT[count_reg[3:0]]))
                        begin
                            match_next = 1'b0;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                mem_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // ram output holds until the next read, so waiting here is safe
                if (slot_free)
                begin
                    valid_next = 1'b1;
                    byte_next  = mem_rdata;
                    last_next  = at_last;
                    olen_next  = len_reg;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                        state_next  = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            match_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            match_reg <= match_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        rd_ptr_reg <= rd_ptr_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        olen_reg   <= olen_next;
    end

    assign out_valid    = valid_reg;
    assign line_byte    = byte_reg;
    assign line_length  = lfpf_pkg::LEN_W'(olen_reg);
    assign last_of_line = last_reg;

endmodule

// ===== hw/rtl/lfpf_ram.sv =====
`timescale 1ns / 1ps

module lfpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/lfpf_checker.sv =====
`timescale 1ns / 1ps

module lfpf_checker #(
    parameter int LINE_CAPACITY = lfpf_pkg::LINE_CAPACITY
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [lfpf_pkg::BYTE_W-1:0] line_byte,
    input logic [lfpf_pkg::LEN_W-1:0]  line_length,
    input logic                        last_of_line
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_byte) && $stable(last_of_line))
        else $error("stalled output word changed");

    // emitted lines carry at least the prefix and fit in the store
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_length >= lfpf_pkg::LEN_W'(lfpf_pkg::PREFIX_LEN)) &&
                      (line_length <= lfpf_pkg::LEN_W'(LINE_CAPACITY - 1)))
        else $error("line length out of range");

    // input stays held off while a line is still being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_line |-> in_stall)
        else $error("input taken in the middle of a line");

    // a line starts only after a ram fetch, when input is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word appeared without a fetch");

    // line length stays the same within one line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_line ##1 out_valid |-> $stable(line_length))
        else $error("line length changed within a line");

endmodule

bind line_framer_prefix_filter_top lfpf_checker #(
    .LINE_CAPACITY (LINE_CAPACITY)
) u_lfpf_checker (.*);

// ===== tb/sv/line_framer_prefix_filter_top_tb.sv =====
`timescale 1ns / 1ps

module line_framer_prefix_filter_top_tb;

    localparam int HOLD_LIMIT     = (lfpf_pkg::LINE_CAPACITY - 1 > 63) ? 63 :
                                    lfpf_pkg::LINE_CAPACITY - 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 70;

    typedef struct packed {
        logic [lfpf_pkg::BYTE_W-1:0] ch;
        logic [lfpf_pkg::LEN_W-1:0]  len;
        logic                        last;
    } line_word_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic [lfpf_pkg::BYTE_W-1:0] rx_byte      = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic [lfpf_pkg::BYTE_W-1:0] line_byte;
    logic [lfpf_pkg::LEN_W-1:0]  line_length;
    logic                        last_of_line;

    // predictor state: the line being collected
    logic [lfpf_pkg::BYTE_W-1:0] held_line [64];
    int                          held_count   = 0;
    line_word_t                  line_q [$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  quiet_cycles = 0;
    int  stall_left   = 0;
    bit  idle_on      = 1'b1;

    line_framer_prefix_filter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_byte    (line_byte),
        .line_length  (line_length),
        .last_of_line (last_of_line)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // update the held line and queue the words a terminator releases
    task automatic frame_byte(input logic [lfpf_pkg::BYTE_W-1:0] b);
        line_word_t w;
        bit         hit;
        if (b == lfpf_pkg::CH_LF || b == lfpf_pkg::CH_CR)
        begin
            if (held_count > 0)
            begin
                hit = (held_count >= lfpf_pkg::PREFIX_LEN);
                for (int i = 0; i < lfpf_pkg::PREFIX_LEN; i++)
                begin
                    if (hit && held_line[i] != lfpf_pkg::PREFIX_TEXT[i])
                        hit = 1'b0;
                end
                if (hit)
                begin
                    for (int k = 0; k < held_count; k++)
                    begin
                        w.ch   = held_line[k];
                        w.len  = held_count[lfpf_pkg::LEN_W-1:0];
                        w.last = (k + 1 == held_count);
                        line_q.push_back(w);
                    end
                end
                held_count = 0;
            end
        end
        else if (held_count < HOLD_LIMIT)
        begin
            held_line[held_count] = b;
            held_count++;
        end
    endtask

    task automatic send_word(input logic [lfpf_pkg::BYTE_W-1:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        frame_byte(b);
        items_sent++;
    endtask

    // sender holds off until every queued word has come out
    task automatic drain_lines();
        in_valid <= 1'b0;
        while (line_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [lfpf_pkg::BYTE_W-1:0] rand_char();
        logic [lfpf_pkg::BYTE_W-1:0] b;
        b = lfpf_pkg::BYTE_W'($urandom_range(0, 255));
        if (b == lfpf_pkg::CH_LF || b == lfpf_pkg::CH_CR)
            b = b ^ 8'h80;
        return b;
    endfunction

    function automatic logic [lfpf_pkg::BYTE_W-1:0] rand_term();
        return ($urandom_range(0, 1) == 0) ? lfpf_pkg::CH_LF : lfpf_pkg::CH_CR;
    endfunction

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i]);
    endtask

    task automatic send_prefix(input int upto);
        for (int i = 0; i < upto; i++)
            send_word(lfpf_pkg::PREFIX_TEXT[i]);
    endtask

    task automatic send_good_line(input int body_len);
        send_prefix(lfpf_pkg::PREFIX_LEN);
        for (int i = 0; i < body_len; i++)
            send_word(rand_char());
        send_word(rand_term());
        if ($urandom_range(0, 3) == 0)
            send_word(rand_term());
    endtask

    // output checker and receiver stall bursts
    always @(posedge clk)
    begin : line_checker
        line_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_q.size() == 0)
            begin
                report_mismatch($sformatf("word %02h with nothing expected", line_byte));
            end
            else
            begin
                w = line_q.pop_front();
                if (line_byte !== w.ch)
                    report_mismatch($sformatf("line_byte %02h expected %02h",
                                              line_byte, w.ch));
                if (line_length !== w.len)
                    report_mismatch($sformatf("line_length %0d expected %0d",
                                              line_length, w.len));
                if (last_of_line !== w.last)
                    report_mismatch($sformatf("last_of_line %0b expected %0b",
                                              last_of_line, w.last));
            end
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // prefix alone, shortest line that passes
    task automatic test_bare_prefix();
        send_prefix(lfpf_pkg::PREFIX_LEN);
        send_word(lfpf_pkg::CH_CR);
        send_prefix(lfpf_pkg::PREFIX_LEN);
        send_word(lfpf_pkg::CH_LF);
        drain_lines();
    endtask

    // short, empty, and near-miss lines all drop
    task automatic test_rejected_lines();
        send_text("+MQ");
        send_word(lfpf_pkg::CH_LF);
        send_word(lfpf_pkg::CH_CR);
        send_word(lfpf_pkg::CH_LF);
        send_word(lfpf_pkg::CH_CR);
        send_text("+MQTTSUBRECV;");
        send_word(lfpf_pkg::CH_CR);
        send_word(lfpf_pkg::CH_LF);
        drain_lines();
    endtask

    // zero bytes and byte extremes in an accepted line
    task automatic test_binary_payload();
        send_prefix(lfpf_pkg::PREFIX_LEN);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h80);
        send_word(8'h7F);
        send_word(8'h00);
        send_word(lfpf_pkg::CH_CR);
        send_word(lfpf_pkg::CH_LF);
        drain_lines();
    endtask

    // overlong line gets cut at the store limit
    task automatic test_truncation();
        send_good_line(HOLD_LIMIT - lfpf_pkg::PREFIX_LEN + 12);
        drain_lines();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int pick;
        int n;
        int pos;
        logic [lfpf_pkg::BYTE_W-1:0] b;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(HOLD_LIMIT - lfpf_pkg::PREFIX_LEN - 2, HOLD_LIMIT);
                else
                    n = $urandom_range(0, 20);
                send_good_line(n);
            end
            else if (pick < 80)
            begin
                // prefix with one character wrong, or cut short
                if ($urandom_range(0, 1) == 0)
                begin
                    pos = $urandom_range(0, lfpf_pkg::PREFIX_LEN - 1);
                    for (int i = 0; i < lfpf_pkg::PREFIX_LEN; i++)
                    begin
                        b = lfpf_pkg::PREFIX_TEXT[i];
                        if (i == pos)
                        begin
                            b = rand_char();
                            if (b == lfpf_pkg::PREFIX_TEXT[i])
                                b = b ^ 8'h01;
                        end
                        send_word(b);
                    end
                end
                else
                begin
                    send_prefix($urandom_range(1, lfpf_pkg::PREFIX_LEN - 1));
                end
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                    send_word(rand_char());
                send_word(rand_term());
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, lfpf_pkg::PREFIX_LEN - 1);
                for (int i = 0; i < n; i++)
                    send_word(rand_char());
                send_word(rand_term());
            end
            else
            begin
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                    send_word(lfpf_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 29) == 0)
                drain_lines();
        end
        send_word(lfpf_pkg::CH_LF);
        drain_lines();
    endtask

    // back to back lines with no idling on either side
    task automatic test_full_rate();
        idle_on = 1'b0;
        send_good_line(4);
        send_good_line(0);
        send_good_line($urandom_range(0, 30));
        drain_lines();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_bare_prefix();
        test_rejected_lines();
        test_binary_payload();
        test_truncation();
        test_random_traffic();
        test_full_rate();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lfpf_pkg.sv
hw/rtl/lfpf_ram.sv
hw/rtl/line_framer_prefix_filter_top.sv
hw/rtl/lfpf_checker.sv
tb/sv/line_framer_prefix_filter_top_tb.sv
